FILE: rtl/prrs_pkg.sv
// Package for the priority round-robin scheduler: sizes, operation codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package prrs_pkg;

    localparam int PRIORITY_LEVELS = 8;
    localparam int THREAD_SLOTS    = 64;

    localparam int LVL_W   = 3;
    localparam int TID_W   = 6;
    localparam int CNT_W   = 7;
    localparam int OP_W    = 3;
    localparam int STEP_W  = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic [CNT_W-1:0]  COUNT_MAX    = 7'd127;
    localparam logic [LVL_W-1:0]  LEAST_URGENT = LVL_W'(PRIORITY_LEVELS - 1);
    localparam logic [STEP_W-1:0] LAST_STEP    = STEP_W'(THREAD_SLOTS - 1);

    typedef enum logic [OP_W-1:0] {
        OP_ADD_HEAD  = 3'd0,
        OP_WAKE_TAIL = 3'd1,
        OP_WAIT      = 3'd2,
        OP_SELECT    = 3'd3,
        OP_RESCHED   = 3'd4,
        OP_PREEMPT   = 3'd5
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IDLE_THREAD = 1'b0,
        CFG_PREEMPT_EN  = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEL_POP,
        ST_WALK,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic sel_pop;
        logic walk;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic go_pop;
        logic go_walk;
        logic walk_done;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/prrs_ctrl.sv
// Controller state machine of the scheduler.
// Depends on prrs_pkg; drives commands to prrs_datapath.
module prrs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  prrs_pkg::dp_status_t status,
    output prrs_pkg::dp_cmd_t    cmd
);
    import prrs_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (status.go_pop)
                    state_next = ST_SEL_POP;
                else if (status.go_walk)
                    state_next = ST_WALK;
                else
                    state_next = ST_RESP;
            end
            ST_SEL_POP:
            begin
                state_next = ST_RESP;
            end
            ST_WALK:
            begin
                if (status.walk_done)
                    state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready     = (state_reg == ST_IDLE);
        cmd.accept   = (state_reg == ST_IDLE) && s_tvalid;
        cmd.exec     = (state_reg == ST_EXEC);
        cmd.sel_pop  = (state_reg == ST_SEL_POP);
        cmd.walk     = (state_reg == ST_WALK);
        cmd.load_out = (state_reg == ST_RESP) && status.out_free;
    end

    // An accepted transaction is always decoded in the following cycle.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg == ST_EXEC))
        else $error("accepted transaction not decoded");

endmodule

FILE: rtl/prrs_datapath.sv
// Datapath of the scheduler: per-level queue state, next-link memory,
// list walk registers, configuration registers and the output register.
// Depends on prrs_pkg; controlled by prrs_ctrl.
module prrs_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  prrs_pkg::dp_cmd_t               cmd,
    output prrs_pkg::dp_status_t            status,
    input  logic [prrs_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [prrs_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [prrs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prrs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import prrs_pkg::*;

    // Per-level state.
    logic [TID_W-1:0] head_reg  [PRIORITY_LEVELS];
    logic [TID_W-1:0] tail_reg  [PRIORITY_LEVELS];
    logic [TID_W-1:0] rslot_reg [PRIORITY_LEVELS];
    logic [CNT_W-1:0] cnt_reg   [PRIORITY_LEVELS];
    logic [PRIORITY_LEVELS-1:0] qne_reg, rsv_reg;

    // Scalar state.
    logic [TID_W-1:0] cur_reg, cur_next;
    logic [LVL_W-1:0] curpri_reg, curpri_next;
    logic             need_reg, need_next;
    logic [TID_W-1:0] idle_thr_reg;
    logic             preempt_en_reg;

    // Captured transaction.
    logic [OP_W-1:0]  op_reg;
    logic [TID_W-1:0] tid_reg;
    logic [LVL_W-1:0] pri_reg;
    logic [LVL_W-1:0] lvl_reg, lvl_next;

    // List walk.
    logic [TID_W-1:0]  walk_cur_reg, walk_cur_next;
    logic [TID_W-1:0]  walk_prev_reg, walk_prev_next;
    logic              walk_first_reg, walk_first_next;
    logic [STEP_W-1:0] steps_reg, steps_next;

    // Result flags.
    logic sel_reg, sel_next, idle_reg, idle_next, err_reg, err_next;

    // Output register.
    logic             out_valid_reg;
    logic [TID_W-1:0] out_thread_reg;
    logic             out_sel_reg, out_idle_reg, out_err_reg;

    // Next-link memory.
    logic [TID_W-1:0] link_mem [THREAD_SLOTS];
    logic [TID_W-1:0] rd_addr, rd_data_reg;
    logic             wr_en;
    logic [TID_W-1:0] wr_addr, wr_data;

    // Update of the addressed level.
    logic [LVL_W-1:0] lvl_sel, lvl_x, scan_lvl;
    logic             any_elig, do_sel, upd;
    logic [PRIORITY_LEVELS-1:0] elig;
    logic [TID_W-1:0] h, t, rs;
    logic [CNT_W-1:0] c;
    logic             q, v;
    logic [TID_W-1:0] head_next, tail_next, rslot_next;
    logic [CNT_W-1:0] cnt_next;
    logic             qne_next, rsv_next;
    op_t              op;

    assign op = op_t'(op_reg);

    always_comb
    begin
        for (int i = 0; i < PRIORITY_LEVELS; i++)
        begin
            elig[i] = (cnt_reg[i] != '0) && (qne_reg[i] || rsv_reg[i]);
        end
        scan_lvl = '0;
        for (int i = PRIORITY_LEVELS - 1; i >= 0; i--)
        begin
            if (elig[i])
                scan_lvl = LVL_W'(i);
        end
        any_elig = |elig;
    end

    assign do_sel = (op == OP_SELECT) || ((op == OP_PREEMPT) && need_reg && preempt_en_reg);

    always_comb
    begin
        case (op)
            OP_ADD_HEAD, OP_WAKE_TAIL: lvl_x = pri_reg;
            OP_WAIT:                   lvl_x = curpri_reg;
            default:                   lvl_x = scan_lvl;
        endcase
    end

    assign lvl_sel = cmd.exec ? lvl_x : lvl_reg;
    assign h = head_reg[lvl_sel];
    assign t = tail_reg[lvl_sel];
    assign rs = rslot_reg[lvl_sel];
    assign c = cnt_reg[lvl_sel];
    assign q = qne_reg[lvl_sel];
    assign v = rsv_reg[lvl_sel];

    always_comb
    begin
        upd = 1'b0;
        head_next = h;
        tail_next = t;
        rslot_next = rs;
        cnt_next = c;
        qne_next = q;
        rsv_next = v;
        cur_next = cur_reg;
        curpri_next = curpri_reg;
        need_next = need_reg;
        lvl_next = lvl_reg;
        walk_cur_next = walk_cur_reg;
        walk_prev_next = walk_prev_reg;
        walk_first_next = walk_first_reg;
        steps_next = steps_reg;
        sel_next = sel_reg;
        idle_next = idle_reg;
        err_next = err_reg;
        wr_en = 1'b0;
        wr_addr = t;
        wr_data = tid_reg;
        rd_addr = h;
        status.go_pop = 1'b0;
        status.go_walk = 1'b0;
        status.walk_done = 1'b0;
        status.out_free = !out_valid_reg || m_tready;

        if (cmd.exec)
        begin
            lvl_next = lvl_x;
            sel_next = 1'b0;
            idle_next = 1'b0;
            err_next = 1'b0;
            case (op)
                OP_ADD_HEAD, OP_WAKE_TAIL:
                begin
                    if (c == COUNT_MAX)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        upd = 1'b1;
                        cnt_next = c + 1'b1;
                        qne_next = 1'b1;
                        if (op == OP_ADD_HEAD)
                        begin
                            if (q)
                            begin
                                wr_en = 1'b1;
                                wr_addr = tid_reg;
                                wr_data = h;
                            end
                            else
                            begin
                                tail_next = tid_reg;
                            end
                            head_next = tid_reg;
                        end
                        else
                        begin
                            if (q)
                            begin
                                wr_en = 1'b1;
                                wr_addr = t;
                                wr_data = tid_reg;
                            end
                            else
                            begin
                                head_next = tid_reg;
                            end
                            tail_next = tid_reg;
                        end
                    end
                end
                OP_WAIT:
                begin
                    if (c == '0)
                    begin
                        err_next = 1'b1;
                    end
                    else if (v && (rs == cur_reg))
                    begin
                        upd = 1'b1;
                        rsv_next = 1'b0;
                        cnt_next = c - 1'b1;
                    end
                    else if (!q)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        // Start the queue walk at the head; its link is read now.
                        status.go_walk = 1'b1;
                        rd_addr = h;
                        walk_cur_next = h;
                        walk_first_next = 1'b1;
                        steps_next = '0;
                    end
                end
                OP_SELECT, OP_PREEMPT:
                begin
                    if (do_sel)
                    begin
                        sel_next = 1'b1;
                        if (op == OP_PREEMPT)
                            need_next = 1'b0;
                        if (!any_elig)
                        begin
                            idle_next = 1'b1;
                            cur_next = idle_thr_reg;
                            curpri_next = LEAST_URGENT;
                        end
                        else if (q)
                        begin
                            status.go_pop = 1'b1;
                            rd_addr = h;
                        end
                        else
                        begin
                            cur_next = rs;
                            curpri_next = lvl_x;
                        end
                    end
                end
                OP_RESCHED:
                begin
                    need_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.sel_pop)
        begin
            // Pop the head, return the old run-slot thread to the tail.
            upd = 1'b1;
            if (h != t)
            begin
                head_next = rd_data_reg;
                if (v)
                begin
                    wr_en = 1'b1;
                    wr_addr = t;
                    wr_data = rs;
                    tail_next = rs;
                end
            end
            else if (v)
            begin
                head_next = rs;
                tail_next = rs;
            end
            else
            begin
                qne_next = 1'b0;
            end
            rslot_next = h;
            rsv_next = 1'b1;
            cur_next = h;
            curpri_next = lvl_reg;
        end
        else if (cmd.walk)
        begin
            // rd_data_reg holds the link of walk_cur_reg.
            if (walk_cur_reg == cur_reg)
            begin
                status.walk_done = 1'b1;
                upd = 1'b1;
                cnt_next = c - 1'b1;
                if (walk_first_reg)
                begin
                    if (walk_cur_reg == t)
                        qne_next = 1'b0;
                    else
                        head_next = rd_data_reg;
                end
                else
                begin
                    wr_en = 1'b1;
                    wr_addr = walk_prev_reg;
                    wr_data = rd_data_reg;
                    if (walk_cur_reg == t)
                        tail_next = walk_prev_reg;
                end
            end
            else if ((walk_cur_reg == t) || (steps_reg == LAST_STEP))
            begin
                status.walk_done = 1'b1;
                err_next = 1'b1;
            end
            else
            begin
                walk_prev_next = walk_cur_reg;
                walk_cur_next = rd_data_reg;
                walk_first_next = 1'b0;
                steps_next = steps_reg + 1'b1;
                rd_addr = rd_data_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            link_mem[wr_addr] <= wr_data;
        rd_data_reg <= link_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            head_reg[lvl_sel] <= head_next;
            tail_reg[lvl_sel] <= tail_next;
            rslot_reg[lvl_sel] <= rslot_next;
        end
        if (cmd.accept)
        begin
            op_reg <= s_tdata[OP_W-1:0];
            tid_reg <= s_tdata[OP_W +: TID_W];
            pri_reg <= s_tdata[OP_W+TID_W +: LVL_W];
        end
        lvl_reg <= lvl_next;
        walk_cur_reg <= walk_cur_next;
        walk_prev_reg <= walk_prev_next;
        walk_first_reg <= walk_first_next;
        steps_reg <= steps_next;
        sel_reg <= sel_next;
        idle_reg <= idle_next;
        err_reg <= err_next;
        if (cmd.load_out)
        begin
            out_thread_reg <= cur_reg;
            out_sel_reg <= sel_reg;
            out_idle_reg <= idle_reg;
            out_err_reg <= err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PRIORITY_LEVELS; i++)
            begin
                cnt_reg[i] <= '0;
            end
            qne_reg <= '0;
            rsv_reg <= '0;
            cur_reg <= '0;
            curpri_reg <= '0;
            need_reg <= 1'b0;
            idle_thr_reg <= '0;
            preempt_en_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (upd)
            begin
                cnt_reg[lvl_sel] <= cnt_next;
                qne_reg[lvl_sel] <= qne_next;
                rsv_reg[lvl_sel] <= rsv_next;
            end
            cur_reg <= cur_next;
            curpri_reg <= curpri_next;
            need_reg <= need_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_IDLE_THREAD: idle_thr_reg <= cfg_data[TID_W-1:0];
                    CFG_PREEMPT_EN:  preempt_en_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {{(OUT_TDATA_W-TID_W-3){1'b0}}, out_err_reg, out_idle_reg,
                      out_sel_reg, out_thread_reg};

    // A delivered selection that found a thread leaves it in its level's run slot.
    a_sel_runslot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && sel_reg && !idle_reg) |->
            (rsv_reg[curpri_reg] && (rslot_reg[curpri_reg] == cur_reg)))
        else $error("selected thread not in run slot");

    // Idle is only ever reported as the outcome of a selection.
    a_idle_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && idle_reg) |-> sel_reg)
        else $error("idle without selection");

    // The walk ends no later than its step limit.
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.walk && (steps_reg == LAST_STEP)) |-> status.walk_done)
        else $error("queue walk overran");

endmodule

FILE: rtl/priority_round_robin_scheduler.sv
// Top level of the multilevel priority round-robin ready-queue scheduler.
// Depends on prrs_pkg, prrs_ctrl and prrs_datapath.
//
//  Channel  Direction  Handshake              Payload
//  s_*      in         s_tvalid / s_tready    s_tdata: operation, thread_id, priority_req
//  m_*      out        m_tvalid / m_tready    m_tdata: thread_out, selected, idle_chosen, error
//  cfg_*    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each transaction passes through accept, execute and respond for add, wake, request,
// preempt checks without selection and selections that keep the run slot; a selection
// that pops a queue adds a pop step, since the next link comes from a registered memory read.
// A wait that must search the queue walks it entry by entry (up to 64 entries),
// one next-link memory read per step. Reset clears all control state at once; no
// clearing pass is needed. A new transaction is taken while the previous result still
// sits in the output register; a stalled output holds the block in its respond cycle.
module priority_round_robin_scheduler (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [2:0] operation, [8:3] thread_id, [11:9] priority_req, [15:12] zero
    input  logic [prrs_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [5:0] thread_out, [6] selected, [7] idle_chosen, [8] error, [15:9] zero
    output logic [prrs_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [prrs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [prrs_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import prrs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Configuration registers are always writable.
    assign cfg_ready = 1'b1;

    // The controller sequences each transaction through decode, memory steps and response.
    prrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the queues, the link memory and the output register.
    prrs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
